// ===== design/weighted_table_sampler_assert.svh =====
// ----------------------------------------------------------------------------
// Weighted table sampler assertion macros
// Shared concurrent assertion forms, sampled on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_TABLE_SAMPLER_ASSERT_SVH
`define WEIGHTED_TABLE_SAMPLER_ASSERT_SVH

// consequent must hold in the same cycle
`define WTS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the following cycle
`define WTS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/wts_pkg.sv =====
// ----------------------------------------------------------------------------
// Weighted table sampler package
// Widths, codes and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package wts_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int INDEX_W     = $clog2(TABLE_DEPTH);
   localparam int COUNT_W     = 9;
   localparam int VALUE_W     = 16;
   localparam int WEIGHT_W    = 32;
   localparam int RANDOM_BITS = 32;
   localparam int SHIFT_W     = 5;
   localparam int CSR_INDEX_W = 4;
   localparam int CSR_DATA_W  = 32;

   localparam logic [COUNT_W-1:0] ENTRY_COUNT_RESET = COUNT_W'(1);
   localparam logic [COUNT_W-1:0] DEPTH_COUNT       = COUNT_W'(TABLE_DEPTH);

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_DRAW = 1'b1
   } opcode_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SHIFT_AMOUNT = CSR_INDEX_W'(0),
      CSR_ENTRY_COUNT  = CSR_INDEX_W'(1)
   } csr_index_type;

   typedef struct packed {
      logic load_en;
      logic draw_start;
      logic walk_en;
      logic post_en;
   } wts_cmd_type;

   typedef struct packed {
      logic hit;
      logic last_entry;
      logic zero_count;
      logic out_free;
   } wts_status_type;

endpackage

// ===== design/wts_req_if.sv =====
// ----------------------------------------------------------------------------
// Weighted table sampler request channel
// Valid/ready channel carrying load and draw requests.
// ----------------------------------------------------------------------------
interface wts_req_if;
   logic                             valid;
   logic                             ready;
   logic                             opcode;
   logic [wts_pkg::INDEX_W-1:0]      entry_index;
   logic [wts_pkg::VALUE_W-1:0]      entry_value;
   logic [wts_pkg::WEIGHT_W-1:0]     entry_weight;
   logic [wts_pkg::RANDOM_BITS-1:0]  random_word;
   logic                             last_in;

   modport source (output valid, opcode, entry_index, entry_value, entry_weight,
                   random_word, last_in, input ready);
   modport sink   (input valid, opcode, entry_index, entry_value, entry_weight,
                   random_word, last_in, output ready);
endinterface

// ===== design/wts_rsp_if.sv =====
// ----------------------------------------------------------------------------
// Weighted table sampler response channel
// Valid/ready channel carrying one sample per draw request.
// ----------------------------------------------------------------------------
interface wts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [wts_pkg::VALUE_W-1:0]  pixel_value;
   logic                         rejected;
   logic                         last_out;

   modport source (output valid, pixel_value, rejected, last_out, input ready);
   modport sink   (input valid, pixel_value, rejected, last_out, output ready);
endinterface

// ===== design/wts_csr_if.sv =====
// ----------------------------------------------------------------------------
// Weighted table sampler register write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
interface wts_csr_if;
   logic                            valid;
   logic                            ready;
   logic [wts_pkg::CSR_INDEX_W-1:0] index;
   logic [wts_pkg::CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== design/wts_controller.sv =====
// ----------------------------------------------------------------------------
// Weighted table sampler controller
// Sequences request acceptance, the table walk and result posting.
// ----------------------------------------------------------------------------
module wts_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_opcode,
   output logic                    req_ready,
   input  wts_pkg::wts_status_type status,
   output wts_pkg::wts_cmd_type    cmd
);

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_DONE
   } state_type;

   state_type state_ff;
   state_type state_in;
   logic      accept;
   logic      is_draw;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign is_draw   = (req_opcode == wts_pkg::OP_DRAW);

   always_comb begin
      cmd.load_en    = accept && !is_draw;
      cmd.draw_start = accept && is_draw;
      cmd.walk_en    = (state_ff == S_WALK);
      cmd.post_en    = (state_ff == S_DONE) && status.out_free;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && is_draw) begin
               state_in = status.zero_count ? S_DONE : S_WALK;
            end
         end
         S_WALK: begin
            if (status.hit || status.last_entry) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (status.out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`include "weighted_table_sampler_assert.svh"

   `WTS_ASSERT_NEXT(a_walk_holds, (state_ff == S_WALK && !status.hit && !status.last_entry), (state_ff == S_WALK), "walk left without hit or end of table")
   `WTS_ASSERT_NEXT(a_draw_leaves_idle, cmd.draw_start, (state_ff != S_IDLE), "draw request did not start a walk")
   `WTS_ASSERT_NEXT(a_post_returns_idle, cmd.post_en, (state_ff == S_IDLE), "posted result did not return to idle")

endmodule

// ===== design/wts_datapath.sv =====
// ----------------------------------------------------------------------------
// Weighted table sampler datapath
// Table memories, registers, remainder walk and output register.
// ----------------------------------------------------------------------------
module wts_datapath (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [wts_pkg::INDEX_W-1:0]      entry_index,
   input  logic [wts_pkg::VALUE_W-1:0]      entry_value,
   input  logic [wts_pkg::WEIGHT_W-1:0]     entry_weight,
   input  logic [wts_pkg::RANDOM_BITS-1:0]  random_word,
   input  logic                             last_in,
   input  wts_pkg::wts_cmd_type             cmd,
   output wts_pkg::wts_status_type          status,
   wts_csr_if.sink                          csr_bus,
   wts_rsp_if.source                        rsp_bus
);

   logic [wts_pkg::VALUE_W-1:0]     value_mem  [wts_pkg::TABLE_DEPTH];
   logic [wts_pkg::WEIGHT_W-1:0]    weight_mem [wts_pkg::TABLE_DEPTH];

   logic [wts_pkg::VALUE_W-1:0]     rd_value_ff;
   logic [wts_pkg::WEIGHT_W-1:0]    rd_weight_ff;
   logic [wts_pkg::INDEX_W-1:0]     rd_addr;
   logic                            rd_en;

   logic [wts_pkg::SHIFT_W-1:0]     shift_ff, shift_in;
   logic [wts_pkg::COUNT_W-1:0]     count_ff, count_in;
   logic [wts_pkg::COUNT_W-1:0]     eff_count;

   logic [wts_pkg::RANDOM_BITS-1:0] remainder_ff, remainder_in;
   logic [wts_pkg::INDEX_W-1:0]     chk_idx_ff, chk_idx_in;
   logic [wts_pkg::INDEX_W-1:0]     next_idx;
   logic                            draw_last_ff, draw_last_in;
   logic [wts_pkg::VALUE_W-1:0]     res_value_ff, res_value_in;
   logic                            res_rej_ff, res_rej_in;

   logic                            rsp_valid_ff, rsp_valid_in;
   logic [wts_pkg::VALUE_W-1:0]     rsp_value_ff, rsp_value_in;
   logic                            rsp_rej_ff, rsp_rej_in;
   logic                            rsp_last_ff, rsp_last_in;

   assign eff_count = (count_ff > wts_pkg::DEPTH_COUNT) ? wts_pkg::DEPTH_COUNT : count_ff;
   assign next_idx  = chk_idx_ff + wts_pkg::INDEX_W'(1);
   assign rd_addr   = cmd.walk_en ? next_idx : '0;
   assign rd_en     = cmd.draw_start || cmd.walk_en;

   always_comb begin
      status.hit        = (remainder_ff < rd_weight_ff);
      status.last_entry = ((wts_pkg::COUNT_W'(chk_idx_ff) + wts_pkg::COUNT_W'(1)) == eff_count);
      status.zero_count = (eff_count == '0);
      status.out_free   = !rsp_valid_ff || rsp_bus.ready;
   end

   // register writes
   assign csr_bus.ready = 1'b1;

   always_comb begin
      shift_in = shift_ff;
      count_in = count_ff;
      if (csr_bus.valid) begin
         unique case (csr_bus.index)
            wts_pkg::CSR_SHIFT_AMOUNT: shift_in = csr_bus.data[wts_pkg::SHIFT_W-1:0];
            wts_pkg::CSR_ENTRY_COUNT:  count_in = csr_bus.data[wts_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // walk: compare against the entry read last cycle, subtract and advance
   always_comb begin
      remainder_in = remainder_ff;
      chk_idx_in   = chk_idx_ff;
      draw_last_in = draw_last_ff;
      res_value_in = res_value_ff;
      res_rej_in   = res_rej_ff;
      if (cmd.draw_start) begin
         remainder_in = random_word >> shift_ff;
         chk_idx_in   = '0;
         draw_last_in = last_in;
         res_value_in = '0;
         res_rej_in   = 1'b1;
      end else if (cmd.walk_en) begin
         if (status.hit) begin
            res_value_in = rd_value_ff;
            res_rej_in   = 1'b0;
         end else begin
            remainder_in = remainder_ff - rd_weight_ff;
            chk_idx_in   = next_idx;
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_rej_in   = rsp_rej_ff;
      rsp_last_in  = rsp_last_ff;
      if (cmd.post_en) begin
         rsp_valid_in = 1'b1;
         rsp_value_in = res_value_ff;
         rsp_rej_in   = res_rej_ff;
         rsp_last_in  = draw_last_ff;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_en) begin
         value_mem[entry_index]  <= entry_value;
         weight_mem[entry_index] <= entry_weight;
      end
      if (rd_en) begin
         rd_value_ff  <= value_mem[rd_addr];
         rd_weight_ff <= weight_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff     <= '0;
         count_ff     <= wts_pkg::ENTRY_COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         shift_ff     <= shift_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      remainder_ff <= remainder_in;
      chk_idx_ff   <= chk_idx_in;
      draw_last_ff <= draw_last_in;
      res_value_ff <= res_value_in;
      res_rej_ff   <= res_rej_in;
      rsp_value_ff <= rsp_value_in;
      rsp_rej_ff   <= rsp_rej_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.pixel_value = rsp_value_ff;
   assign rsp_bus.rejected    = rsp_rej_ff;
   assign rsp_bus.last_out    = rsp_last_ff;

`include "weighted_table_sampler_assert.svh"

   `WTS_ASSERT_SAME(a_post_needs_room, cmd.post_en, (!rsp_valid_ff || rsp_bus.ready), "result posted over a stalled response")
   `WTS_ASSERT_SAME(a_walk_in_range, cmd.walk_en, (wts_pkg::COUNT_W'(chk_idx_ff) < eff_count), "walk beyond entries in use")
   `WTS_ASSERT_SAME(a_rsp_from_post, $rose(rsp_valid_ff), $past(cmd.post_en), "response raised without a post")

endmodule

// ===== design/weighted_table_sampler.sv =====
// ----------------------------------------------------------------------------
// Weighted table sampler
// Draws pixel values from a stored value/weight histogram by inverse
// transform over a linear walk of the table.
// ----------------------------------------------------------------------------
//  channel   direction  carries
//  req_bus   in         opcode, entry_index/value/weight, random_word, last_in
//  rsp_bus   out        pixel_value, rejected, last_out (one per draw)
//  csr_bus   in         index, data (shift_amount, entry_count)
//
//  Load: the entry is written when the request is accepted. Draw: an accept,
//  a walk of one table entry at a time (up to the chosen entry, or over the
//  entries in use), then posting; the walk uses the single table read port.
//  A finished result waits in the output register while the next request
//  is taken. Reset is synchronous; the table keeps no reset and the user must
//  load it before it is read; the block does not enforce this.
// ----------------------------------------------------------------------------
module weighted_table_sampler (
   input  logic      clock,
   input  logic      reset,
   wts_req_if.sink   req_bus,
   wts_rsp_if.source rsp_bus,
   wts_csr_if.sink   csr_bus
);

   wts_pkg::wts_cmd_type    cmd;
   wts_pkg::wts_status_type status;
   logic                    req_ready;

   assign req_bus.ready = req_ready;

   wts_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_bus.valid),
      .req_opcode (req_bus.opcode),
      .req_ready  (req_ready),
      .status     (status),
      .cmd        (cmd)
   );

   wts_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .entry_index  (req_bus.entry_index),
      .entry_value  (req_bus.entry_value),
      .entry_weight (req_bus.entry_weight),
      .random_word  (req_bus.random_word),
      .last_in      (req_bus.last_in),
      .cmd          (cmd),
      .status       (status),
      .csr_bus      (csr_bus),
      .rsp_bus      (rsp_bus)
   );

endmodule
